@@ rtl/hpq_pkg.sv @@
// ----------------------------------------------------------------------------
// hpq_pkg: shared types and constants of the heap priority queue
// Depth, index widths, operation and status codes, compare request.
// ----------------------------------------------------------------------------
package hpq_pkg;

	localparam int HEAP_DEPTH = 64;
	localparam int DATA_W     = 32;
	localparam int ADDR_W     = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
	localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
	localparam int IDX_W      = ADDR_W + 2;

	typedef enum logic {
		KIND_INSERT  = 1'b0,
		KIND_EXTRACT = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;
		logic                     max_first;
	} cmp_req_t;

endpackage

@@ rtl/hpq_ram.sv @@
// ----------------------------------------------------------------------------
// hpq_ram: generic single-port-write, single-port-read memory
// One write and one read per cycle; read data registered.
// ----------------------------------------------------------------------------
module hpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/hpq_cmp.sv @@
// ----------------------------------------------------------------------------
// hpq_cmp: shared priority compare unit
// True when operand a must sit above operand b in the selected order.
// ----------------------------------------------------------------------------
module hpq_cmp (
	input  hpq_pkg::cmp_req_t req,
	output logic              better
);
	import hpq_pkg::*;

	assign better = req.max_first ? (req.a > req.b) : (req.a < req.b);

endmodule

@@ rtl/binary_heap_priority_queue.sv @@
// Insert moves up one level per parent read and compare; extract reads the root
// and the last entry, then moves down one level per read of the children, a pick
// between two children and a move; empty and full errors finish from idle. A new
// request is taken the cycle after its result loads: one request at a time, paced
// by the single read and single write port of the heap memory and one shared compare.
// Reset clears the entry count and the order bit; heap memory is not cleared.
// ----------------------------------------------------------------------------
// binary_heap_priority_queue: sequenced binary heap of signed 32-bit values
// Insert sifts up, extract returns root and sifts the last entry down.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic                                 cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 kind,
	input  logic signed [hpq_pkg::DATA_W-1:0]    value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [hpq_pkg::DATA_W-1:0]    out_value,
	output logic [1:0]                           status
);
	import hpq_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_UP_RD   = 9'b000000010,
		S_UP_CMP  = 9'b000000100,
		S_EX_ROOT = 9'b000001000,
		S_EX_LAST = 9'b000010000,
		S_DN_RDL  = 9'b000100000,
		S_DN_RDR  = 9'b001000000,
		S_DN_PICK = 9'b010000000,
		S_DN_MOVE = 9'b100000000
	} state_t;

	state_t                   state_q;
	logic                     fin_q;
	logic                     order_q;
	logic [CNT_W-1:0]         count_q;
	logic [ADDR_W-1:0]        pos_q;
	logic [ADDR_W-1:0]        child_pos_q;
	logic signed [DATA_W-1:0] val_q;
	logic signed [DATA_W-1:0] child_q;
	logic signed [DATA_W-1:0] left_q;
	logic signed [DATA_W-1:0] res_val_q;
	status_t                  res_status_q;

	logic                     wen;
	logic [ADDR_W-1:0]        waddr;
	logic [DATA_W-1:0]        wdata;
	logic [ADDR_W-1:0]        raddr;
	logic [DATA_W-1:0]        rdata;
	logic signed [DATA_W-1:0] rd_val;

	cmp_req_t                 cmp_req;
	logic                     cmp_better;

	logic [ADDR_W-1:0]        parent;
	logic [IDX_W-1:0]         left_idx;
	logic [IDX_W-1:0]         right_idx;
	logic [IDX_W-1:0]         count_x;
	logic                     accept;
	logic                     out_load;

	hpq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(HEAP_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wen),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	hpq_cmp u_cmp (
		.req    (cmp_req),
		.better (cmp_better)
	);

	assign rd_val    = signed'(rdata);
	assign parent    = (pos_q - 1'b1) >> 1;
	assign left_idx  = {1'b0, pos_q, 1'b1};
	assign right_idx = left_idx + 1'b1;
	assign count_x   = IDX_W'(count_q);
	assign in_ready  = (state_q == S_IDLE) && !fin_q;
	assign accept    = in_valid && in_ready;
	assign out_load  = fin_q && (!out_valid || out_ready);

	always_comb begin
		cmp_req.max_first = order_q;
		cmp_req.a         = val_q;
		cmp_req.b         = rd_val;
		unique case (state_q)
			S_DN_PICK: begin
				cmp_req.a = rd_val;
				cmp_req.b = left_q;
			end
			S_DN_MOVE: begin
				cmp_req.a = child_q;
				cmp_req.b = val_q;
			end
			default: begin
				cmp_req.a = val_q;
				cmp_req.b = rd_val;
			end
		endcase
	end

	always_comb begin
		wen   = 1'b0;
		waddr = pos_q;
		wdata = val_q;
		raddr = '0;
		unique case (state_q)
			S_UP_RD: begin
				if (pos_q == '0) begin
					wen = 1'b1;
				end else begin
					raddr = parent;
				end
			end
			S_UP_CMP: begin
				wen = 1'b1;
				if (cmp_better) begin
					wdata = rd_val;
				end
			end
			S_EX_ROOT: begin
				raddr = count_q[ADDR_W-1:0];
			end
			S_DN_RDL: begin
				if (left_idx >= count_x) begin
					wen = 1'b1;
				end else begin
					raddr = left_idx[ADDR_W-1:0];
				end
			end
			S_DN_RDR: begin
				raddr = right_idx[ADDR_W-1:0];
			end
			S_DN_MOVE: begin
				wen = 1'b1;
				if (cmp_better) begin
					wdata = child_q;
				end
			end
			default: begin
				wen = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fin_q   <= 1'b0;
			order_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (cfg_we) begin
				order_q <= cfg_wdata;
			end
			if (out_load) begin
				fin_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (kind == KIND_INSERT) begin
							if (count_q == CNT_W'(HEAP_DEPTH)) begin
								fin_q <= 1'b1;
							end else begin
								count_q <= count_q + 1'b1;
								state_q <= S_UP_RD;
							end
						end else begin
							if (count_q == '0) begin
								fin_q <= 1'b1;
							end else begin
								count_q <= count_q - 1'b1;
								state_q <= S_EX_ROOT;
							end
						end
					end
				end
				S_UP_RD: begin
					if (pos_q == '0) begin
						fin_q   <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_UP_CMP;
					end
				end
				S_UP_CMP: begin
					if (cmp_better) begin
						state_q <= S_UP_RD;
					end else begin
						fin_q   <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_EX_ROOT: begin
					if (count_q == '0) begin
						fin_q   <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_EX_LAST;
					end
				end
				S_EX_LAST: begin
					state_q <= S_DN_RDL;
				end
				S_DN_RDL: begin
					if (left_idx >= count_x) begin
						fin_q   <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DN_RDR;
					end
				end
				S_DN_RDR: begin
					if (right_idx < count_x) begin
						state_q <= S_DN_PICK;
					end else begin
						state_q <= S_DN_MOVE;
					end
				end
				S_DN_PICK: begin
					state_q <= S_DN_MOVE;
				end
				S_DN_MOVE: begin
					if (cmp_better) begin
						state_q <= S_DN_RDL;
					end else begin
						fin_q   <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_val_q    <= '0;
					res_status_q <= ST_OK;
					val_q        <= value;
					pos_q        <= count_q[ADDR_W-1:0];
					if (kind == KIND_INSERT) begin
						if (count_q == CNT_W'(HEAP_DEPTH)) begin
							res_status_q <= ST_FULL;
						end
					end else if (count_q == '0) begin
						res_status_q <= ST_EMPTY;
					end
				end
			end
			S_UP_CMP: begin
				if (cmp_better) begin
					pos_q <= parent;
				end
			end
			S_EX_ROOT: begin
				res_val_q <= rd_val;
			end
			S_EX_LAST: begin
				val_q <= rd_val;
				pos_q <= '0;
			end
			S_DN_RDR: begin
				left_q      <= rd_val;
				child_q     <= rd_val;
				child_pos_q <= left_idx[ADDR_W-1:0];
			end
			S_DN_PICK: begin
				if (cmp_better) begin
					child_q     <= rd_val;
					child_pos_q <= right_idx[ADDR_W-1:0];
				end else begin
					child_q     <= left_q;
					child_pos_q <= left_idx[ADDR_W-1:0];
				end
			end
			S_DN_MOVE: begin
				if (cmp_better) begin
					pos_q <= child_pos_q;
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value <= res_val_q;
			status    <= res_status_q;
		end
	end

endmodule
